[sv/wtss_pkg.sv]
package wtss_pkg;

  // Defaults for the top-level parameters
  localparam int ENTRIES_DEF      = 16;
  localparam int WINDOW_DEPTH_DEF = 5;
  localparam int COUNT_BITS_DEF   = 48;

  // Fixed field widths
  localparam int KEY_W      = 64;
  localparam int TIME_W     = 64;
  localparam int INTERVAL_W = 32;
  localparam int FLOOR_W    = 48;
  localparam int MINS_W     = 3;
  localparam int STRAT_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // Register reset values
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET    = INTERVAL_W'(2000000);
  localparam logic [FLOOR_W-1:0]    READ_FLOOR_RESET  = FLOOR_W'(500);
  localparam logic [FLOOR_W-1:0]    WRITE_FLOOR_RESET = FLOOR_W'(10);
  localparam logic [MINS_W-1:0]     MIN_SAMPLES_RESET = MINS_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERVAL    = 2'd0,
    CFG_READ_FLOOR  = 2'd1,
    CFG_WRITE_FLOOR = 2'd2,
    CFG_MIN_SAMPLES = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    ACT_POLL   = 1'b0,
    ACT_RETIRE = 1'b1
  } action_t;

  localparam logic [STRAT_W-1:0] STRAT_TIERED  = 2'd0;
  localparam logic [STRAT_W-1:0] STRAT_LEVELED = 2'd1;

  typedef struct packed {
    logic [INTERVAL_W-1:0] min_interval;
    logic [FLOOR_W-1:0]    read_floor;
    logic [FLOOR_W-1:0]    write_floor;
    logic [MINS_W-1:0]     min_samples;
  } cfg_t;

  // Control travelling alongside an item between stages
  typedef struct packed {
    logic               valid;
    logic               decide;
    logic               full;
    logic [STRAT_W-1:0] strategy;
  } item_ctl_t;

  function automatic int pow5(input int k);
    int r;
    r = 1;
    for (int j = 0; j < k; j++) r = r * 5;
    return r;
  endfunction

endpackage

[sv/workload_trend_strategy_switcher.sv]
// Workload trend strategy switcher.
//
// Command channel: drive start with action, file_key, now_us, read_count,
// write_count and strategy; the beat is taken at a clock edge where start is
// high and busy is low. A poll appends the counts to the file's history
// when they have moved and decides whether to switch tiered/leveled; a
// retire frees the file's table entry and returns an all-zero result.
// Result channel: done marks the single result beat of each item for one
// cycle, with rewrite, new_strategy and table_full beside it. The receiver
// cannot stall, so nothing ever waits on the output side.
// The path from the accepting edge to the edge that takes the result runs
// through item register, table lookup and history update, weighted delta
// sums, trend decision and result register. One item is taken every cycle
// while busy is low; the table is written as the item leaves the lookup
// stage, so back-to-back items on the same file see each other's updates.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write only
// while the block is idle. cfg_ready is always high.
// Reset (rst, synchronous) empties the table, clears the last switch time
// and loads the register defaults; busy is high through reset and the
// cycle after it.
module workload_trend_strategy_switcher #(
  parameter int ENTRIES      = wtss_pkg::ENTRIES_DEF,
  parameter int WINDOW_DEPTH = wtss_pkg::WINDOW_DEPTH_DEF,
  parameter int COUNT_BITS   = wtss_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action,
  input  logic [wtss_pkg::KEY_W-1:0]      file_key,
  input  logic [wtss_pkg::TIME_W-1:0]     now_us,
  input  logic [COUNT_BITS-1:0]           read_count,
  input  logic [COUNT_BITS-1:0]           write_count,
  input  logic [wtss_pkg::STRAT_W-1:0]    strategy,
  output logic                            done,
  output logic                            rewrite,
  output logic                            new_strategy,
  output logic                            table_full,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wtss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wtss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wtss_pkg::*;

  localparam int SAMPLE_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W    = COUNT_BITS + 3 * (WINDOW_DEPTH - 1);

  cfg_t                                  cfg;
  logic                                  accept;

  item_ctl_t                             tbl_ctl;
  logic [SAMPLE_W-1:0]                   tbl_count;
  logic [TIME_W-1:0]                     tbl_now;
  logic [COUNT_BITS-1:0]                 tbl_read;
  logic [COUNT_BITS-1:0]                 tbl_write;
  logic [WINDOW_DEPTH-1:0][COUNT_BITS-1:0] tbl_read_hist;
  logic [WINDOW_DEPTH-1:0][COUNT_BITS-1:0] tbl_write_hist;

  item_ctl_t                             trd_ctl;
  logic [SAMPLE_W-1:0]                   trd_count;
  logic [TIME_W-1:0]                     trd_now;
  logic [COUNT_BITS-1:0]                 trd_read;
  logic [COUNT_BITS-1:0]                 trd_write;
  logic [SUM_W-1:0]                      trd_sum_r;
  logic [SUM_W-1:0]                      trd_sum_w;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Hold off the command channel until the cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Register file: truncate each beat to the register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_interval <= INTERVAL_RESET;
      cfg.read_floor   <= READ_FLOOR_RESET;
      cfg.write_floor  <= WRITE_FLOOR_RESET;
      cfg.min_samples  <= MIN_SAMPLES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INTERVAL:    cfg.min_interval <= cfg_data[INTERVAL_W-1:0];
        CFG_READ_FLOOR:  cfg.read_floor   <= cfg_data[FLOOR_W-1:0];
        CFG_WRITE_FLOOR: cfg.write_floor  <= cfg_data[FLOOR_W-1:0];
        CFG_MIN_SAMPLES: cfg.min_samples  <= cfg_data[MINS_W-1:0];
      endcase
    end
  end

  wtss_table #(
    .ENTRIES      (ENTRIES),
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .COUNT_BITS   (COUNT_BITS)
  ) u_table (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .action         (action),
    .file_key       (file_key),
    .now_us         (now_us),
    .read_count     (read_count),
    .write_count    (write_count),
    .strategy       (strategy),
    .out_ctl        (tbl_ctl),
    .out_count      (tbl_count),
    .out_now        (tbl_now),
    .out_read       (tbl_read),
    .out_write      (tbl_write),
    .out_read_hist  (tbl_read_hist),
    .out_write_hist (tbl_write_hist)
  );

  wtss_trend #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .COUNT_BITS   (COUNT_BITS)
  ) u_trend (
    .clk           (clk),
    .rst           (rst),
    .in_ctl        (tbl_ctl),
    .in_count      (tbl_count),
    .in_now        (tbl_now),
    .in_read       (tbl_read),
    .in_write      (tbl_write),
    .in_read_hist  (tbl_read_hist),
    .in_write_hist (tbl_write_hist),
    .out_ctl       (trd_ctl),
    .out_count     (trd_count),
    .out_now       (trd_now),
    .out_read      (trd_read),
    .out_write     (trd_write),
    .out_sum_r     (trd_sum_r),
    .out_sum_w     (trd_sum_w)
  );

  wtss_decide #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .COUNT_BITS   (COUNT_BITS)
  ) u_decide (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_ctl       (trd_ctl),
    .in_count     (trd_count),
    .in_now       (trd_now),
    .in_read      (trd_read),
    .in_write     (trd_write),
    .in_sum_r     (trd_sum_r),
    .in_sum_w     (trd_sum_w),
    .done         (done),
    .rewrite      (rewrite),
    .new_strategy (new_strategy),
    .table_full   (table_full)
  );

endmodule

[sv/wtss_table.sv]
module wtss_table #(
  parameter int ENTRIES      = 16,
  parameter int WINDOW_DEPTH = 5,
  parameter int COUNT_BITS   = 48,
  localparam int SAMPLE_W    = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  logic                                  action,
  input  logic [wtss_pkg::KEY_W-1:0]            file_key,
  input  logic [wtss_pkg::TIME_W-1:0]           now_us,
  input  logic [COUNT_BITS-1:0]                 read_count,
  input  logic [COUNT_BITS-1:0]                 write_count,
  input  logic [wtss_pkg::STRAT_W-1:0]          strategy,
  output wtss_pkg::item_ctl_t                   out_ctl,
  output logic [SAMPLE_W-1:0]                   out_count,
  output logic [wtss_pkg::TIME_W-1:0]           out_now,
  output logic [COUNT_BITS-1:0]                 out_read,
  output logic [COUNT_BITS-1:0]                 out_write,
  output logic [WINDOW_DEPTH-1:0][COUNT_BITS-1:0] out_read_hist,
  output logic [WINDOW_DEPTH-1:0][COUNT_BITS-1:0] out_write_hist
);
  import wtss_pkg::*;

  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int POS_W  = $clog2(WINDOW_DEPTH);

  typedef logic [WINDOW_DEPTH-1:0][COUNT_BITS-1:0] hist_t;

  // Item register
  logic                  in_valid;
  logic                  in_action;
  logic [KEY_W-1:0]      in_key;
  logic [TIME_W-1:0]     in_now;
  logic [COUNT_BITS-1:0] in_read;
  logic [COUNT_BITS-1:0] in_write;
  logic [STRAT_W-1:0]    in_strategy;

  // Per-file table
  logic [ENTRIES-1:0]    entry_valid;
  logic [KEY_W-1:0]      entry_key [ENTRIES];
  logic [SAMPLE_W-1:0]   sample_count [ENTRIES];
  hist_t                 read_hist [ENTRIES];
  hist_t                 write_hist [ENTRIES];

  logic [ENTRIES-1:0]    hit_vec;
  logic                  hit_any;
  logic                  free_any;
  logic [SLOT_W-1:0]     hit_slot;
  logic [SLOT_W-1:0]     free_slot;
  logic [SLOT_W-1:0]     slot;
  logic                  is_poll;
  logic                  store;
  logic [SAMPLE_W-1:0]   n_cur;
  logic [SAMPLE_W-1:0]   n_m1;
  logic [POS_W-1:0]      last_idx;
  logic                  changed;
  hist_t                 row_r;
  hist_t                 row_w;
  hist_t                 new_r;
  hist_t                 new_w;
  logic [SAMPLE_W-1:0]   n_new;

  always_comb begin
    hit_slot  = '0;
    free_slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = entry_valid[i] && (entry_key[i] == in_key);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_slot = SLOT_W'(i);
      if (!entry_valid[i]) free_slot = SLOT_W'(i);
    end
  end

  assign hit_any  = |hit_vec;
  assign free_any = ~&entry_valid;
  assign slot     = hit_any ? hit_slot : free_slot;
  assign is_poll  = (action_t'(in_action) == ACT_POLL);
  assign store    = in_valid && is_poll && (hit_any || free_any);

  // A new file starts with an empty history
  assign n_cur    = hit_any ? sample_count[slot] : '0;
  assign row_r    = read_hist[slot];
  assign row_w    = write_hist[slot];
  assign n_m1     = n_cur - SAMPLE_W'(1);
  assign last_idx = n_m1[POS_W-1:0];
  assign changed  = (n_cur == '0) || (row_r[last_idx] != in_read) ||
                    (row_w[last_idx] != in_write);

  always_comb begin
    new_r = row_r;
    new_w = row_w;
    n_new = n_cur;
    if (changed) begin
      if (n_cur == SAMPLE_W'(WINDOW_DEPTH)) begin
        // Drop the oldest sample
        for (int j = 0; j < WINDOW_DEPTH - 1; j++) begin
          new_r[j] = row_r[j+1];
          new_w[j] = row_w[j+1];
        end
        new_r[WINDOW_DEPTH-1] = in_read;
        new_w[WINDOW_DEPTH-1] = in_write;
      end else begin
        new_r[n_cur[POS_W-1:0]] = in_read;
        new_w[n_cur[POS_W-1:0]] = in_write;
        n_new = n_cur + SAMPLE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      entry_valid  <= '0;
      sample_count <= '{default: '0};
      out_ctl      <= '0;
    end else begin
      in_valid <= accept;
      if (in_valid && !is_poll && hit_any) begin
        entry_valid[hit_slot]  <= 1'b0;
        sample_count[hit_slot] <= '0;
      end
      if (store) begin
        entry_valid[slot]  <= 1'b1;
        sample_count[slot] <= n_new;
      end
      out_ctl.valid    <= in_valid;
      out_ctl.decide   <= store;
      out_ctl.full     <= in_valid && is_poll && !hit_any && !free_any;
      out_ctl.strategy <= in_strategy;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_action   <= action;
      in_key      <= file_key;
      in_now      <= now_us;
      in_read     <= read_count;
      in_write    <= write_count;
      in_strategy <= strategy;
    end
    if (store) begin
      entry_key[slot]  <= in_key;
      read_hist[slot]  <= new_r;
      write_hist[slot] <= new_w;
    end
    out_count      <= n_new;
    out_now        <= in_now;
    out_read       <= in_read;
    out_write      <= in_write;
    out_read_hist  <= new_r;
    out_write_hist <= new_w;
  end

endmodule

[sv/wtss_trend.sv]
module wtss_trend #(
  parameter int WINDOW_DEPTH = 5,
  parameter int COUNT_BITS   = 48,
  localparam int SAMPLE_W    = $clog2(WINDOW_DEPTH + 1),
  localparam int SUM_W       = COUNT_BITS + 3 * (WINDOW_DEPTH - 1)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  wtss_pkg::item_ctl_t                   in_ctl,
  input  logic [SAMPLE_W-1:0]                   in_count,
  input  logic [wtss_pkg::TIME_W-1:0]           in_now,
  input  logic [COUNT_BITS-1:0]                 in_read,
  input  logic [COUNT_BITS-1:0]                 in_write,
  input  logic [WINDOW_DEPTH-1:0][COUNT_BITS-1:0] in_read_hist,
  input  logic [WINDOW_DEPTH-1:0][COUNT_BITS-1:0] in_write_hist,
  output wtss_pkg::item_ctl_t                   out_ctl,
  output logic [SAMPLE_W-1:0]                   out_count,
  output logic [wtss_pkg::TIME_W-1:0]           out_now,
  output logic [COUNT_BITS-1:0]                 out_read,
  output logic [COUNT_BITS-1:0]                 out_write,
  output logic [SUM_W-1:0]                      out_sum_r,
  output logic [SUM_W-1:0]                      out_sum_w
);
  import wtss_pkg::*;

  // Term i carries 5^(i-1) * 4^(depth-1-i): the sum is the scaled average
  // left-shifted by 2*(depth-n), so both sums share one scale.
  logic [SUM_W-1:0] term_r [WINDOW_DEPTH];
  logic [SUM_W-1:0] term_w [WINDOW_DEPTH];
  logic [SUM_W-1:0] sum_r_next;
  logic [SUM_W-1:0] sum_w_next;

  assign term_r[0] = '0;
  assign term_w[0] = '0;

  for (genvar i = 1; i < WINDOW_DEPTH; i++) begin : g_term
    localparam int WEIGHT = pow5(i - 1) * (1 << (2 * (WINDOW_DEPTH - 1 - i)));
    logic                  live;
    logic [COUNT_BITS-1:0] delta_r;
    logic [COUNT_BITS-1:0] delta_w;

    assign live    = (in_count > SAMPLE_W'(i));
    // Clamp falling counts to a zero delta
    assign delta_r = (live && in_read_hist[i] >= in_read_hist[i-1]) ?
                     in_read_hist[i] - in_read_hist[i-1] : '0;
    assign delta_w = (live && in_write_hist[i] >= in_write_hist[i-1]) ?
                     in_write_hist[i] - in_write_hist[i-1] : '0;
    assign term_r[i] = SUM_W'(delta_r) * SUM_W'(WEIGHT);
    assign term_w[i] = SUM_W'(delta_w) * SUM_W'(WEIGHT);
  end

  always_comb begin
    sum_r_next = '0;
    sum_w_next = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      sum_r_next = sum_r_next + term_r[i];
      sum_w_next = sum_w_next + term_w[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    out_count <= in_count;
    out_now   <= in_now;
    out_read  <= in_read;
    out_write <= in_write;
    out_sum_r <= sum_r_next;
    out_sum_w <= sum_w_next;
  end

endmodule

[sv/wtss_decide.sv]
module wtss_decide #(
  parameter int WINDOW_DEPTH = 5,
  parameter int COUNT_BITS   = 48,
  localparam int SAMPLE_W    = $clog2(WINDOW_DEPTH + 1),
  localparam int SUM_W       = COUNT_BITS + 3 * (WINDOW_DEPTH - 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  wtss_pkg::cfg_t              cfg,
  input  wtss_pkg::item_ctl_t         in_ctl,
  input  logic [SAMPLE_W-1:0]         in_count,
  input  logic [wtss_pkg::TIME_W-1:0] in_now,
  input  logic [COUNT_BITS-1:0]       in_read,
  input  logic [COUNT_BITS-1:0]       in_write,
  input  logic [SUM_W-1:0]            in_sum_r,
  input  logic [SUM_W-1:0]            in_sum_w,
  output logic                        done,
  output logic                        rewrite,
  output logic                        new_strategy,
  output logic                        table_full
);
  import wtss_pkg::*;

  localparam int TREND_W = SUM_W + 3;

  logic [TIME_W-1:0]  last_switch_time;
  logic [TIME_W-1:0]  elapsed;
  logic               enough;
  logic               interval_ok;
  logic [TREND_W-1:0] ext_r;
  logic [TREND_W-1:0] ext_w;
  logic [TREND_W-1:0] r_x7;
  logic [TREND_W-1:0] r_x3;
  logic [TREND_W-1:0] w_x7;
  logic [TREND_W-1:0] w_x3;
  logic               up_ok;
  logic               down_ok;
  logic               fire;

  assign enough      = (8'(in_count) >= 8'd2) && (8'(in_count) >= 8'(cfg.min_samples));
  assign elapsed     = in_now - last_switch_time;
  assign interval_ok = !(elapsed < TIME_W'(cfg.min_interval));

  assign ext_r = TREND_W'(in_sum_r);
  assign ext_w = TREND_W'(in_sum_w);
  assign r_x7  = (ext_r << 3) - ext_r;
  assign r_x3  = (ext_r << 1) + ext_r;
  assign w_x7  = (ext_w << 3) - ext_w;
  assign w_x3  = (ext_w << 1) + ext_w;

  // Read share above 0.3 and enough reads: move to leveled, and the mirror
  assign up_ok   = (r_x7 > w_x3) && (64'(in_read) > 64'(cfg.read_floor));
  assign down_ok = (w_x7 > r_x3) && (64'(in_write) > 64'(cfg.write_floor));

  always_comb begin
    fire = 1'b0;
    if (in_ctl.valid && in_ctl.decide && enough && interval_ok) begin
      case (in_ctl.strategy)
        STRAT_TIERED:  fire = up_ok;
        STRAT_LEVELED: fire = down_ok;
        default:       fire = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done             <= 1'b0;
      rewrite          <= 1'b0;
      new_strategy     <= 1'b0;
      table_full       <= 1'b0;
      last_switch_time <= '0;
    end else begin
      done         <= in_ctl.valid;
      rewrite      <= fire;
      new_strategy <= fire && (in_ctl.strategy == STRAT_TIERED);
      table_full   <= in_ctl.valid && in_ctl.full;
      if (fire) last_switch_time <= in_now;
    end
  end

endmodule

[sv/wtss_checker.sv]
module wtss_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic action,
  input logic done,
  input logic rewrite,
  input logic new_strategy,
  input logic table_full
);

  // Every accepted beat yields exactly one result beat through the pipeline registers
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted beat produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result beat without an accepted beat");

  a_retire_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action) |-> ##4 (!rewrite && !new_strategy && !table_full))
    else $error("retire produced a non-zero result");

  a_flags_consistent: assert property (@(posedge clk) disable iff (rst)
    (rewrite || new_strategy || table_full) |->
      (done && !(rewrite && table_full) && (rewrite || !new_strategy)))
    else $error("inconsistent result flags");

endmodule

bind workload_trend_strategy_switcher wtss_checker u_checker (.*);
